// ----- hw/rtl/tomp_pkg.sv -----
// Shared types and constants for the TCP option MSS parser.
package tomp_pkg;

	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned MSS_W    = 16;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned APB_DW   = 32;
	localparam int unsigned APB_AW   = 3;

	localparam logic [MSS_W-1:0]  CAP_RESET   = MSS_W'(1460);
	localparam logic [BYTE_W-1:0] KIND_END    = BYTE_W'(0);
	localparam logic [BYTE_W-1:0] KIND_NOP    = BYTE_W'(1);
	localparam logic [BYTE_W-1:0] KIND_MSS    = BYTE_W'(2);
	localparam logic [BYTE_W-1:0] MIN_OPT_LEN = BYTE_W'(2);
	localparam logic [BYTE_W-1:0] MSS_OPT_LEN = BYTE_W'(4);

	// Register index of the cap in the register file.
	localparam logic [0:0] REG_MSS_CAP = 1'b0;

	typedef enum logic [2:0] {
		PH_KIND   = 3'd0,
		PH_LEN    = 3'd1,
		PH_MSS_HI = 3'd2,
		PH_MSS_LO = 3'd3,
		PH_SKIP   = 3'd4,
		PH_DONE   = 3'd5
	} phase_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_CONSUMED  = 2'd0,
		ST_END_LIST  = 2'd1,
		ST_BAD_LEN   = 2'd2,
		ST_TRUNCATED = 2'd3
	} status_t;

endpackage

// ----- hw/rtl/tomp_if.sv -----
// Stream interfaces for option bytes in and parse results out.
interface tomp_in_if
	import tomp_pkg::*;
	();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] option_byte;
	logic              last_byte;

	modport source (output valid, output option_byte, output last_byte, input ready);
	modport sink   (input valid, input option_byte, input last_byte, output ready);
endinterface

interface tomp_out_if
	import tomp_pkg::*;
	();
	logic                valid;
	logic                ready;
	logic [MSS_W-1:0]    negotiated_mss;
	logic                mss_found;
	logic [STATUS_W-1:0] stop_status;

	modport source (output valid, output negotiated_mss, output mss_found,
		output stop_status, input ready);
	modport sink   (input valid, input negotiated_mss, input mss_found,
		input stop_status, output ready);
endinterface

// ----- hw/rtl/tcp_option_mss_parser.sv -----
// TCP option area parser that extracts the peer MSS.
//
// Usage:
//   opt_in carries the option area one byte per item, in order, with last_byte
//   set on the final byte. res_out carries one result item per area: the
//   negotiated MSS (clamped peer MSS, or the cap when no MSS option was taken),
//   a found flag and the stop status. Bytes that are not final give no result.
//   mss_cap sits at APB byte address 0; write it only while the block is idle.
// Timing:
//   A byte is registered in the input register at acceptance and parsed
//   there; a final byte's result is then loaded into the result register.
//   One byte is taken every cycle while no final byte waits; the parse state
//   is a single small update per byte between the input and result registers.
// Reset:
//   arst_n clears the parse state, empties both registers and sets mss_cap to
//   1460.
// Stall:
//   The result register holds while res_out.ready is low. Non-final bytes keep
//   flowing; a final byte waits in the input register, and opt_in.ready drops,
//   only while an untaken result still fills the result register.
module tcp_option_mss_parser
	import tomp_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	tomp_in_if.sink           opt_in,
	tomp_out_if.source        res_out
);

	// Configuration register
	logic [MSS_W-1:0] cap_q;
	logic             reg_sel;

	assign reg_sel = (paddr[2] == REG_MSS_CAP);
	assign pready  = 1'b1;
	assign prdata  = reg_sel ? APB_DW'(cap_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			cap_q <= pwdata[MSS_W-1:0];
		end
	end

	// Input register
	logic              in_valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              last_s1;
	logic              s1_adv;
	logic              out_valid_q;
	logic              out_load;

	// A final byte needs room in the result register; other bytes never wait.
	assign s1_adv       = in_valid_s1 && (!last_s1 || !out_valid_q || res_out.ready);
	assign opt_in.ready = !in_valid_s1 || s1_adv;
	assign out_load     = s1_adv && last_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (opt_in.ready) begin
			in_valid_s1 <= opt_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (opt_in.valid && opt_in.ready) begin
			byte_s1 <= opt_in.option_byte;
			last_s1 <= opt_in.last_byte;
		end
	end

	// Parse state
	phase_t            phase_q, phase_nxt;
	logic [BYTE_W-1:0] kind_q, kind_nxt;
	logic [BYTE_W-1:0] skip_q, skip_nxt;
	logic [BYTE_W-1:0] mss_hi_q, mss_hi_nxt;
	logic [MSS_W-1:0]  held_mss_q, held_mss_nxt;
	logic              found_q, found_nxt;
	status_t           status_q, status_nxt;
	logic [MSS_W-1:0]  peer_mss;
	status_t           res_status;
	logic [MSS_W-1:0]  res_mss;

	assign peer_mss = {mss_hi_q, byte_s1};

	always_comb begin
		phase_nxt    = phase_q;
		kind_nxt     = kind_q;
		skip_nxt     = skip_q;
		mss_hi_nxt   = mss_hi_q;
		held_mss_nxt = held_mss_q;
		found_nxt    = found_q;
		status_nxt   = status_q;

		case (phase_q)
			PH_KIND: begin
				if (byte_s1 == KIND_END) begin
					status_nxt = ST_END_LIST;
					phase_nxt  = PH_DONE;
				end else if (byte_s1 != KIND_NOP) begin
					kind_nxt  = byte_s1;
					phase_nxt = PH_LEN;
				end
			end
			PH_LEN: begin
				if (byte_s1 < MIN_OPT_LEN) begin
					status_nxt = ST_BAD_LEN;
					phase_nxt  = PH_DONE;
				end else if (kind_q == KIND_MSS && byte_s1 == MSS_OPT_LEN) begin
					phase_nxt = PH_MSS_HI;
				end else if (byte_s1 == MIN_OPT_LEN) begin
					phase_nxt = PH_KIND;
				end else begin
					skip_nxt  = byte_s1 - MIN_OPT_LEN;
					phase_nxt = PH_SKIP;
				end
			end
			PH_MSS_HI: begin
				mss_hi_nxt = byte_s1;
				phase_nxt  = PH_MSS_LO;
			end
			PH_MSS_LO: begin
				// Clamp with the cap in force when the low byte arrives.
				held_mss_nxt = (peer_mss < cap_q) ? peer_mss : cap_q;
				found_nxt    = 1'b1;
				phase_nxt    = PH_KIND;
			end
			PH_SKIP: begin
				skip_nxt = skip_q - BYTE_W'(1);
				if (skip_q == BYTE_W'(1)) begin
					phase_nxt = PH_KIND;
				end
			end
			default: begin
				// Stopped: drop bytes until the final one.
			end
		endcase

		if (phase_nxt == PH_DONE) begin
			res_status = status_nxt;
		end else if (phase_nxt == PH_KIND) begin
			res_status = ST_CONSUMED;
		end else begin
			res_status = ST_TRUNCATED;
		end
		res_mss = found_nxt ? held_mss_nxt : cap_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_KIND;
			kind_q     <= '0;
			skip_q     <= '0;
			mss_hi_q   <= '0;
			held_mss_q <= '0;
			found_q    <= 1'b0;
			status_q   <= ST_CONSUMED;
		end else if (s1_adv) begin
			if (last_s1) begin
				// Final byte: start the next area from a clean state.
				phase_q    <= PH_KIND;
				kind_q     <= '0;
				skip_q     <= '0;
				mss_hi_q   <= '0;
				held_mss_q <= '0;
				found_q    <= 1'b0;
				status_q   <= ST_CONSUMED;
			end else begin
				phase_q    <= phase_nxt;
				kind_q     <= kind_nxt;
				skip_q     <= skip_nxt;
				mss_hi_q   <= mss_hi_nxt;
				held_mss_q <= held_mss_nxt;
				found_q    <= found_nxt;
				status_q   <= status_nxt;
			end
		end
	end

	// Result register
	logic [MSS_W-1:0]    res_mss_q;
	logic                res_found_q;
	logic [STATUS_W-1:0] res_status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (res_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			res_mss_q    <= res_mss;
			res_found_q  <= found_nxt;
			res_status_q <= res_status;
		end
	end

	assign res_out.valid          = out_valid_q;
	assign res_out.negotiated_mss = res_mss_q;
	assign res_out.mss_found      = res_found_q;
	assign res_out.stop_status    = res_status_q;

endmodule

// ----- hw/rtl/tomp_checker.sv -----
// Port-level checks for the TCP option MSS parser, bound to the top level.
module tomp_checker
	import tomp_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input logic                in_last,
	input logic                out_valid,
	input logic                out_ready,
	input logic [MSS_W-1:0]    out_mss,
	input logic [STATUS_W-1:0] out_status
);

	// A result appears only after a final byte has passed the input register and is loaded into the result register.
	a_result_follows_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready && in_last, 2))
		else $error("result without a final byte two cycles earlier");

	// Input backpressure comes only from a stalled, full result register.
	a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (out_valid && !out_ready))
		else $error("input stalled while result side is free");

	// A stalled result holds its payload.
	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(out_mss)
			&& $stable(out_status)))
		else $error("stalled result changed");

	// A non-final byte never produces a result, unless a final byte taken just
	// before it is still on its way to the result register.
	a_no_result_mid_area: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && !in_last && !out_valid
			&& !$past(in_valid && in_ready && in_last)) |=> !out_valid)
		else $error("result raised after a non-final byte");

endmodule

bind tcp_option_mss_parser tomp_checker u_tomp_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (opt_in.valid),
	.in_ready   (opt_in.ready),
	.in_last    (opt_in.last_byte),
	.out_valid  (res_out.valid),
	.out_ready  (res_out.ready),
	.out_mss    (res_out.negotiated_mss),
	.out_status (res_out.stop_status)
);
